// File: src/dpd_pkg.sv
// Shared types and constants for the debug packet deframer.
package dpd_pkg;

  localparam logic [31:0] SIG_VALUE    = 32'h0050_4144;
  localparam logic [7:0]  TYPE_REQUEST = 8'h01;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int HdrStored = 7;
  localparam int HdrCntW   = 3;

  typedef enum logic [1:0] {
    K_DATA  = 2'd0,
    K_EMPTY = 2'd1,
    K_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE = 2'd0,
    E_SIG  = 2'd1,
    E_TYPE = 2'd2,
    E_LEN  = 2'd3
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    err_t       err;
  } res_t;

endpackage

// File: src/dpd_front.sv
// Front end: accepts stream beats, parses frame headers and classifies each beat.
module dpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [7:0]         in_rx_byte,
  output logic               push_valid,
  output dpd_pkg::res_t      push_res,
  input  logic               push_ready
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HOLD    = 2'd2
  } phase_t;

  phase_t                                phase_r, phase_nxt;
  logic [dpd_pkg::HdrCntW-1:0]           cnt_r, cnt_nxt;
  logic [dpd_pkg::HdrStored-1:0][7:0]    hdr_r, hdr_nxt;
  logic [15:0]                           rem_r, rem_nxt;
  logic [15:0]                           max_len_r;

  logic        accept;
  logic [31:0] sig;
  logic [15:0] len;
  logic [7:0]  typ;
  dpd_pkg::err_t err;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign sig = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign len = {hdr_r[5], hdr_r[4]};
  assign typ = hdr_r[6];

  always_comb begin
    if (sig != dpd_pkg::SIG_VALUE) begin
      err = dpd_pkg::E_SIG;
    end else if (typ != dpd_pkg::TYPE_REQUEST) begin
      err = dpd_pkg::E_TYPE;
    end else if (len > max_len_r) begin
      err = dpd_pkg::E_LEN;
    end else begin
      err = dpd_pkg::E_NONE;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    hdr_nxt    = hdr_r;
    rem_nxt    = rem_r;
    push_valid = 1'b0;
    push_res   = '{kind: dpd_pkg::K_DATA, data: 8'd0, last: 1'b0, err: dpd_pkg::E_NONE};
    if (accept) begin
      if (in_action) begin
        phase_nxt = PH_HEADER;
        cnt_nxt   = '0;
        rem_nxt   = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (cnt_r != dpd_pkg::HdrCntW'(dpd_pkg::HdrStored)) begin
              hdr_nxt[cnt_r] = in_rx_byte;
              cnt_nxt        = cnt_r + 1'b1;
            end else begin
              cnt_nxt = '0;
              if (err != dpd_pkg::E_NONE) begin
                phase_nxt      = PH_HOLD;
                rem_nxt        = '0;
                push_valid     = 1'b1;
                push_res.kind  = dpd_pkg::K_ERROR;
                push_res.err   = err;
              end else if (len == 16'd0) begin
                phase_nxt      = PH_HEADER;
                rem_nxt        = '0;
                push_valid     = 1'b1;
                push_res.kind  = dpd_pkg::K_EMPTY;
                push_res.last  = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
                rem_nxt   = len;
              end
            end
          end
          PH_PAYLOAD: begin
            push_valid    = 1'b1;
            push_res.data = in_rx_byte;
            if (rem_r <= 16'd1) begin
              push_res.last = 1'b1;
              rem_nxt       = '0;
              phase_nxt     = PH_HEADER;
            end else begin
              rem_nxt = rem_r - 16'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      cnt_r     <= '0;
      rem_r     <= '0;
      max_len_r <= dpd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
    hdr_r <= hdr_nxt;
  end

endmodule

// File: src/dpd_queue.sv
// Short result queue between the parsing front end and the output stage.
module dpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  dpd_pkg::res_t push_res,
  output logic          push_ready,
  output logic          pop_valid,
  output dpd_pkg::res_t pop_res,
  input  logic          pop_ready
);

  dpd_pkg::res_t               mem_r [dpd_pkg::QDepth];
  logic [dpd_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dpd_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dpd_pkg::QCntW-1:0]   cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign push_ready = cnt_r != dpd_pkg::QCntW'(dpd_pkg::QDepth);
  assign pop_valid  = cnt_r != '0;
  assign pop_res    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == dpd_pkg::QPtrW'(dpd_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == dpd_pkg::QPtrW'(dpd_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

// File: src/dpd_back.sv
// Back end: output register that presents one result beat at a time.
module dpd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  input  dpd_pkg::res_t pop_res,
  output logic          pop_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_data_byte,
  output logic          out_last_of_frame,
  output logic [1:0]    out_error_code
);

  logic          valid_r;
  dpd_pkg::res_t res_r;

  assign pop_ready         = !valid_r || out_ready;
  assign out_valid         = valid_r;
  assign out_kind          = res_r.kind;
  assign out_data_byte     = res_r.data;
  assign out_last_of_frame = res_r.last;
  assign out_error_code    = res_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
    if (pop_ready && pop_valid) begin
      res_r <= pop_res;
    end
  end

endmodule

// File: src/debug_packet_deframer_unit.sv
// Top level of the debug packet deframer: parser, result queue and output stage.
// Throughput: one beat per cycle in, one result beat per cycle out, while out_ready stays high.
// A result goes into the queue first, then into the output register that drives the outputs.
// The parser works one beat per cycle; a two-entry queue and the output register absorb stalls.
// Reset is synchronous and active low: parser, queue and output clear, and the
// maximum payload length returns to 1024.
module debug_packet_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last_of_frame,
  output logic [1:0]  out_error_code
);

  logic          push_valid, push_ready;
  dpd_pkg::res_t push_res;
  logic          pop_valid, pop_ready;
  dpd_pkg::res_t pop_res;

  dpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_res   (push_res),
    .push_ready (push_ready)
  );

  dpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_res  (push_res),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_res   (pop_res),
    .pop_ready (pop_ready)
  );

  dpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_res          (pop_res),
    .pop_ready        (pop_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_error_code   (out_error_code)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("result pushed into a full queue");

  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action) |-> !push_valid)
    else $error("restart beat produced a result");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == dpd_pkg::K_ERROR) |->
      (out_error_code != dpd_pkg::E_NONE && !out_last_of_frame && out_data_byte == 8'd0))
    else $error("error result carries inconsistent fields");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == dpd_pkg::K_EMPTY) |->
      (out_last_of_frame && out_error_code == dpd_pkg::E_NONE && out_data_byte == 8'd0))
    else $error("empty-frame result carries inconsistent fields");

endmodule

// File: bench/debug_packet_deframer_unit_tb.sv
// Self-checking testbench for the debug packet deframer, with a behavioral parser model.
module debug_packet_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HOLD    = 2'd2
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_last_of_frame;
  logic [1:0]  out_error_code;

  logic [15:0]  max_len_q;
  parse_phase_t phase_q;
  logic [2:0]   hdr_cnt_q;
  logic [55:0]  hdr_q;
  logic [15:0]  pay_left_q;

  dpd_pkg::res_t frame_results[$];
  int   fail_cnt = 0;
  int   beats_sent = 0;
  int   cycle_cnt = 0;
  int   burst_left = 0;
  int   ready_mode = 0;
  int   ready_ctr = 0;

  debug_packet_deframer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_error_code   (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_parser();
    phase_q    = PH_HEADER;
    hdr_cnt_q  = 3'd0;
    hdr_q      = 56'd0;
    pay_left_q = 16'd0;
  endfunction

  function automatic bit deframe_step(input logic act, input logic [7:0] b,
                                      output dpd_pkg::res_t r);
    logic [31:0]   sig;
    logic [15:0]   len;
    logic [7:0]    typ;
    dpd_pkg::err_t err;
    r = '{dpd_pkg::K_DATA, 8'h00, 1'b0, dpd_pkg::E_NONE};
    if (act) begin
      clear_parser();
      return 1'b0;
    end
    case (phase_q)
      PH_HEADER: begin
        if (hdr_cnt_q != 3'd7) begin
          hdr_q[hdr_cnt_q*8 +: 8] = b;
          hdr_cnt_q = hdr_cnt_q + 3'd1;
          return 1'b0;
        end
        sig = hdr_q[31:0];
        len = hdr_q[47:32];
        typ = hdr_q[55:48];
        hdr_cnt_q = 3'd0;
        hdr_q = 56'd0;
        if (sig != dpd_pkg::SIG_VALUE) err = dpd_pkg::E_SIG;
        else if (typ != dpd_pkg::TYPE_REQUEST) err = dpd_pkg::E_TYPE;
        else if (len > max_len_q) err = dpd_pkg::E_LEN;
        else err = dpd_pkg::E_NONE;
        if (err != dpd_pkg::E_NONE) begin
          phase_q = PH_HOLD;
          pay_left_q = 16'd0;
          r.kind = dpd_pkg::K_ERROR;
          r.err = err;
          return 1'b1;
        end
        if (len == 16'd0) begin
          r.kind = dpd_pkg::K_EMPTY;
          r.last = 1'b1;
          return 1'b1;
        end
        phase_q = PH_PAYLOAD;
        pay_left_q = len;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        r.data = b;
        r.last = (pay_left_q <= 16'd1);
        if (r.last) begin
          pay_left_q = 16'd0;
          phase_q = PH_HEADER;
        end else begin
          pay_left_q = pay_left_q - 16'd1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    dpd_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_cnt++;
      end else begin
        want = frame_results.pop_front();
        if (out_kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          fail_cnt++;
        end
        if (out_data_byte != want.data) begin
          $error("data_byte: expected %0d, got %0d", want.data, out_data_byte);
          fail_cnt++;
        end
        if (out_last_of_frame != want.last) begin
          $error("last_of_frame: expected %0d, got %0d", want.last, out_last_of_frame);
          fail_cnt++;
        end
        if (out_error_code != want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_error_code);
          fail_cnt++;
        end
      end
    end
    ready_ctr++;
    if (ready_ctr % 64 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (ready_ctr % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_beat(input logic act, input logic [7:0] b);
    dpd_pkg::res_t r;
    int            gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (!(act == 1'b0 && phase_q == PH_HOLD)) beats_sent++;
    if (deframe_step(act, b, r)) frame_results.push_back(r);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    burst_left = 0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    pause_input();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len_q = v;
  endtask

  function automatic void push_header(ref logic [7:0] fb[$], input logic [31:0] sig,
                                      input logic [15:0] len, input logic [7:0] typ);
    for (int i = 0; i < 4; i++) fb.push_back(sig[i*8 +: 8]);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    fb.push_back(typ);
    fb.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_bytes(input logic [7:0] fb[$], input int n);
    for (int i = 0; i < n; i++) send_beat(1'b0, fb[i]);
  endtask

  task automatic send_random_frame();
    logic [7:0]  fb[$];
    logic [31:0] sig;
    logic [7:0]  typ;
    int          len;
    int          cap;
    int          sel;
    int          n;
    sig = dpd_pkg::SIG_VALUE;
    typ = dpd_pkg::TYPE_REQUEST;
    cap = (max_len_q < 16) ? max_len_q : 16;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, (max_len_q < 300) ? max_len_q : 300);
    else len = $urandom_range(0, cap);
    sel = $urandom_range(0, 99);
    if (sel >= 92) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_beat(1'b0, 8'($urandom_range(0, 255)));
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      return;
    end
    if (sel >= 60 && sel < 68) begin
      if ($urandom_range(0, 1) != 0) sig = $urandom;
      else sig = dpd_pkg::SIG_VALUE ^ (32'd1 << $urandom_range(0, 31));
      typ = 8'($urandom_range(0, 255));
      len = $urandom_range(0, 65535);
    end else if (sel >= 68 && sel < 76) begin
      do typ = 8'($urandom_range(0, 255)); while (typ == dpd_pkg::TYPE_REQUEST);
      len = $urandom_range(0, 65535);
    end else if (sel >= 76 && sel < 84 && max_len_q != 16'hFFFF) begin
      if ($urandom_range(0, 1) != 0)
        len = $urandom_range(max_len_q + 1, (max_len_q > 65527) ? 65535 : max_len_q + 8);
      else
        len = $urandom_range(max_len_q + 1, 65535);
    end
    push_header(fb, sig, len[15:0], typ);
    if (sig == dpd_pkg::SIG_VALUE && typ == dpd_pkg::TYPE_REQUEST && len <= max_len_q)
      repeat (len) fb.push_back(8'($urandom_range(0, 255)));
    n = (sel >= 84) ? $urandom_range(1, fb.size() - 1) : fb.size();
    send_bytes(fb, n);
    if (sel >= 60) begin
      if (phase_q == PH_HOLD) begin
        repeat ($urandom_range(0, 3)) send_beat(1'b0, 8'($urandom_range(0, 255)));
      end
      send_beat(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_traffic(input int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) send_random_frame();
  endtask

  task automatic test_directed_frames();
    logic [7:0] fb[$];
    push_header(fb, dpd_pkg::SIG_VALUE, 16'd0, dpd_pkg::TYPE_REQUEST);
    push_header(fb, dpd_pkg::SIG_VALUE, 16'd1, dpd_pkg::TYPE_REQUEST);
    fb.push_back(8'hFF);
    push_header(fb, dpd_pkg::SIG_VALUE, 16'hFFFF, 8'hFF);
    fb.push_back(8'h00);
    send_bytes(fb, fb.size());
    send_beat(1'b1, 8'hFF);
  endtask

  task automatic test_default_limit();
    run_random_traffic(180);
  endtask

  task automatic test_zero_limit();
    write_max_len(16'd0);
    run_random_traffic(90);
  endtask

  task automatic test_full_limit();
    write_max_len(16'hFFFF);
    run_random_traffic(120);
  endtask

  task automatic test_random_limit();
    write_max_len(16'($urandom_range(1, 40)));
    run_random_traffic(160);
  endtask

  initial begin
    max_len_q = dpd_pkg::MAX_LEN_RESET;
    clear_parser();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_default_limit();
    test_zero_limit();
    test_full_limit();
    test_random_limit();
    pause_input();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/dpd_pkg.sv
src/dpd_front.sv
src/dpd_queue.sv
src/dpd_back.sv
src/debug_packet_deframer_unit.sv
bench/debug_packet_deframer_unit_tb.sv
